// File: hw/rtl/ssmc_pkg.sv
// ============================================================================
// ssmc_pkg - shared types and constants for the substring match capitalizer
// Item and result layouts, pattern configuration bundle, character codes and
// configuration register indexes.
// ============================================================================
`default_nettype none

package ssmc_pkg;

    // Longest pattern supported; the working buffer holds one full window.
    localparam int MAX_PATTERN = 16;
    localparam int BUF_DEPTH   = MAX_PATTERN;
    // Counter wide enough to hold a full window count.
    localparam int CNT_W       = $clog2(MAX_PATTERN + 1);
    localparam int LEN_W       = 5;
    localparam int BYTE_W      = 8;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 2;

    // Depth of the item queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN  = 2'd2;

    // ASCII lowercase range and the case offset.
    localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [BYTE_W-1:0] CHAR_LOWER_Z = 8'h7a;
    localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'd32;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              end_of_text;
    } item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_byte;
    } result_t;

    typedef struct packed {
        logic [MAX_PATTERN-1:0][BYTE_W-1:0] pattern;
        logic [LEN_W-1:0]                   act_len;
    } cfg_t;

endpackage

`default_nettype wire

// File: hw/rtl/ssmc_front.sv
// ============================================================================
// ssmc_front - input acceptance and item queue
// Accepts text items on the input handshake and holds them in a short queue
// until the back end pops them.
// ============================================================================
`default_nettype none

module ssmc_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire ssmc_pkg::item_t in_item,
    output logic               q_valid,
    output ssmc_pkg::item_t    q_item,
    input  wire logic          q_pop
);
    import ssmc_pkg::*;

    item_t              q_mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               push;
    logic               pop;

    assign in_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = q_mem_reg[rd_ptr_reg];

    assign push = in_valid && in_ready;
    assign pop  = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage: payload only, no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/ssmc_back.sv
// ============================================================================
// ssmc_back - window engine and output register
// Appends queued bytes to the window, compares a full window with the pattern,
// capitalizes on a match and emits one byte per cycle unless the output stalls.
// ============================================================================
`default_nettype none

module ssmc_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire ssmc_pkg::cfg_t  cfg,
    input  wire logic            q_valid,
    input  wire ssmc_pkg::item_t q_item,
    output logic                 q_pop,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output ssmc_pkg::result_t    out_item
);
    import ssmc_pkg::*;

    logic [BUF_DEPTH-1:0][BYTE_W-1:0] work_reg;
    logic [BUF_DEPTH-1:0][BYTE_W-1:0] work_next;
    logic [CNT_W-1:0]                 cnt_reg;
    logic [CNT_W-1:0]                 cnt_next;
    logic                             end_reg;
    logic                             end_next;
    logic                             busy_reg;
    logic                             busy_next;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    result_t                          out_item_reg;

    logic [BUF_DEPTH-1:0][BYTE_W-1:0] view;
    logic [BUF_DEPTH-1:0][BYTE_W-1:0] mod;
    logic [BUF_DEPTH-1:0]             hit;
    logic [CNT_W-1:0]                 vcnt;
    logic [CNT_W-1:0]                 rem;
    logic [CNT_W-1:0]                 keep;
    logic                             vend;
    logic                             load;
    logic                             active;
    logic                             emit_need;
    logic                             take;
    logic                             emit;
    logic                             match;

    assign take  = !out_valid_reg || out_ready;
    assign load  = !busy_reg && q_valid;
    assign q_pop = load;

    always_comb
    begin
        // Window as seen this cycle, with a newly popped byte appended.
        for (int k = 0; k < BUF_DEPTH; k++)
        begin
            view[k] = (load && (CNT_W'(k) == cnt_reg)) ? q_item.text_byte : work_reg[k];
        end
        vcnt   = load ? cnt_reg + 1'b1 : cnt_reg;
        vend   = load ? q_item.end_of_text : end_reg;
        active = busy_reg || load;
        keep   = (cfg.act_len == '0) ? '0 : CNT_W'(cfg.act_len - 1'b1);

        emit_need = active && ((vcnt > keep) || (vend && (vcnt != '0)));

        // Full window: compare every pattern position in parallel.
        for (int k = 0; k < BUF_DEPTH; k++)
        begin
            hit[k] = (LEN_W'(k) >= cfg.act_len) || (view[k] == cfg.pattern[k]);
        end
        match = (cfg.act_len != '0) && (vcnt == CNT_W'(cfg.act_len)) && (&hit);

        for (int k = 0; k < BUF_DEPTH; k++)
        begin
            if (match && (LEN_W'(k) < cfg.act_len)
                && (view[k] >= CHAR_LOWER_A) && (view[k] <= CHAR_LOWER_Z))
            begin
                mod[k] = view[k] - CASE_OFFSET;
            end
            else
            begin
                mod[k] = view[k];
            end
        end

        emit = emit_need && take;
        rem  = vcnt - 1'b1;

        work_next = work_reg;
        cnt_next  = cnt_reg;
        end_next  = end_reg;
        busy_next = busy_reg;
        if (emit)
        begin
            // Drop the oldest byte and advance the window.
            for (int k = 0; k < BUF_DEPTH - 1; k++)
            begin
                work_next[k] = mod[k + 1];
            end
            work_next[BUF_DEPTH-1] = mod[BUF_DEPTH-1];
            cnt_next  = rem;
            end_next  = vend;
            busy_next = (rem > keep) || (vend && (rem != '0));
        end
        else if (load)
        begin
            work_next = view;
            cnt_next  = vcnt;
            end_next  = vend;
            busy_next = emit_need;
        end

        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            end_reg       <= 1'b0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            end_reg       <= end_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        if (emit)
        begin
            out_item_reg.out_byte  <= mod[0];
            out_item_reg.last_byte <= vend && (vcnt == CNT_W'(1));
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

// File: hw/rtl/substring_match_capitalizer.sv
// ============================================================================
// substring_match_capitalizer - streaming substring match capitalizer
// Text bytes enter one item per handshake; the block keeps the last
// pattern_length-1 bytes in a window and, when a new byte completes a full
// window that equals the configured pattern, uppercases every lowercase letter
// in it before the oldest byte leaves. Overlapping matches compare against
// bytes already capitalized. An item flagged end_of_text flushes the window,
// and the final result carries last_byte. A pattern_length of 0 passes bytes
// straight through; values above 16 act as 16. An accepted item enters a
// two-entry queue and is popped by the window engine when it is not busy;
// the engine emits one result per cycle into an output register while that
// register is free, and an item produces one result in steady state, up to
// 16 for an end-of-text flush or after the length was shortened. An item
// passes through the queue and its result through the output register
// before the result is offered. Configuration writes are taken at once
// (cfg_ready is always high) and must only occur while idle.
// ============================================================================
`default_nettype none

module substring_match_capitalizer (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [ssmc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ssmc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [ssmc_pkg::BYTE_W-1:0]     text_byte,
    input  wire logic                            end_of_text,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [ssmc_pkg::BYTE_W-1:0]          out_byte,
    output logic                                 last_byte
);
    import ssmc_pkg::*;

    logic [CFG_DATA_W-1:0] pattern_low_reg;
    logic [CFG_DATA_W-1:0] pattern_high_reg;
    logic [LEN_W-1:0]      pattern_length_reg;

    cfg_t    cfg;
    item_t   in_item;
    item_t   q_item;
    result_t out_item;
    logic    q_valid;
    logic    q_pop;
    logic    cfg_write;

    // Configuration port never stalls.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_PATTERN_LOW:  pattern_low_reg    <= cfg_data;
                CFG_PATTERN_HIGH: pattern_high_reg   <= cfg_data;
                CFG_PATTERN_LEN:  pattern_length_reg <= cfg_data[LEN_W-1:0];
                default:          ; // unmapped index: drop the write
            endcase
        end
    end

    // Pattern bytes, byte 0 in the low bits of pattern_low; clamp the length.
    assign cfg.pattern = {pattern_high_reg, pattern_low_reg};
    assign cfg.act_len = (pattern_length_reg > LEN_W'(MAX_PATTERN))
                         ? LEN_W'(MAX_PATTERN) : pattern_length_reg;

    assign in_item.text_byte   = text_byte;
    assign in_item.end_of_text = end_of_text;

    // Front: accept items and hold them in the queue.
    ssmc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // Back: window, compare, capitalize, emit.
    ssmc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    assign out_byte  = out_item.out_byte;
    assign last_byte = out_item.last_byte;

endmodule

`default_nettype wire

// File: hw/rtl/ssmc_checker.sv
// ============================================================================
// ssmc_checker - port-level checks for the substring match capitalizer
// Tracks bytes and end-of-text markers in flight and checks the output side.
// ============================================================================
`default_nettype none

module ssmc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       end_of_text,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic       last_byte
);
    // Queue, window buffer and output register hold at most this many bytes.
    localparam logic [4:0] MAX_HELD = 5'd19;

    logic [4:0] held_reg;
    logic [2:0] ends_reg;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            ends_reg <= '0;
        end
        else
        begin
            held_reg <= held_reg + {4'd0, in_acc} - {4'd0, out_acc};
            ends_reg <= ends_reg + {2'd0, in_acc && end_of_text}
                        - {2'd0, out_acc && last_byte};
        end
    end

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_byte))
        else $error("stalled result changed or dropped");

    // A result needs an accepted byte behind it.
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> held_reg != 5'd0)
        else $error("result without a pending input byte");

    // Bytes in flight stay within the storage of the block.
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= MAX_HELD)
        else $error("more bytes in flight than the block can hold");

    // A final marker only follows an accepted end of text.
    a_last_src: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_byte |-> ends_reg != 3'd0)
        else $error("last_byte without an accepted end of text");

endmodule

bind substring_match_capitalizer ssmc_checker u_ssmc_checker (.*);

`default_nettype wire

// File: sim/caps_check_pkg.sv
// ============================================================================
// caps_check_pkg - scoreboard for the substring match capitalizer
// Keeps its own copy of the pattern registers and of the pending text window,
// works out the bytes that each text item releases, and checks the results
// of the block against them in order.
// ============================================================================
package caps_check_pkg;

    timeunit 1ns;
    timeprecision 1ps;

    import ssmc_pkg::*;

    class caps_tracker;

        logic [BYTE_W-1:0] pattern [MAX_PATTERN];
        logic [LEN_W-1:0]  pattern_len;
        logic [BYTE_W-1:0] window_q [$];
        result_t           expected_out [$];
        int                errors;
        int                items;
        int                results;

        function new();
            foreach (pattern[k]) pattern[k] = '0;
            pattern_len = '0;
            errors      = 0;
            items       = 0;
            results     = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            int k;
            case (idx)
                CFG_PATTERN_LOW:
                    for (k = 0; k < 8; k++) pattern[k] = data[8*k +: 8];
                CFG_PATTERN_HIGH:
                    for (k = 0; k < 8; k++) pattern[8+k] = data[8*k +: 8];
                CFG_PATTERN_LEN:
                    pattern_len = data[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        // Release bytes for one accepted text item.
        function void note_text_item(logic [BYTE_W-1:0] text, logic eot);
            logic [BYTE_W-1:0] work [$];
            result_t           step_out [$];
            result_t           r;
            int                eff;
            int                keep;
            int                k;
            bit                hit;
            items++;
            eff  = (pattern_len > MAX_PATTERN) ? MAX_PATTERN : int'(pattern_len);
            keep = (eff == 0) ? 0 : eff - 1;
            work = window_q;
            work.push_back(text);
            // Surplus bytes leave unmodified; only a window of exactly eff is compared.
            while (work.size() > keep) begin
                if (eff > 0 && work.size() == eff) begin
                    hit = 1'b1;
                    for (k = 0; k < eff; k++)
                        if (work[k] != pattern[k]) hit = 1'b0;
                    if (hit)
                        for (k = 0; k < eff; k++)
                            if (work[k] >= CHAR_LOWER_A && work[k] <= CHAR_LOWER_Z)
                                work[k] = work[k] - CASE_OFFSET;
                end
                r.out_byte  = work.pop_front();
                r.last_byte = 1'b0;
                step_out.push_back(r);
            end
            if (eot) begin
                while (work.size() > 0) begin
                    r.out_byte  = work.pop_front();
                    r.last_byte = 1'b0;
                    step_out.push_back(r);
                end
                r = step_out.pop_back();
                r.last_byte = 1'b1;
                step_out.push_back(r);
            end
            window_q = work;
            foreach (step_out[k]) expected_out.push_back(step_out[k]);
        endfunction

        function void check_out(logic [BYTE_W-1:0] got_byte, logic got_last);
            result_t want;
            results++;
            if (expected_out.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual out_byte %h last_byte %b",
                         $time, got_byte, got_last);
                return;
            end
            want = expected_out.pop_front();
            if (got_byte !== want.out_byte) begin
                errors++;
                $display("%0t: out_byte mismatch, expected %h actual %h",
                         $time, want.out_byte, got_byte);
            end
            if (got_last !== want.last_byte) begin
                errors++;
                $display("%0t: last_byte mismatch, expected %b actual %b",
                         $time, want.last_byte, got_last);
            end
        endfunction

        function int pending();
            return expected_out.size();
        endfunction

    endclass

endpackage

// File: sim/tb_top.sv
// ============================================================================
// tb_top - testbench for the substring match capitalizer
// Drives text items and pattern register writes through valid/ready channels,
// predicts every released byte with the scoreboard, and checks results in
// order under several sender and receiver idle patterns, including a long
// receiver hold that backs the block up.
// ============================================================================
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import ssmc_pkg::*;
    import caps_check_pkg::*;

    localparam int PHASES     = 10;
    localparam int PHASE_ITEMS = 16;
    localparam int LONG_HOLD  = 300;
    localparam int SETTLE_CYC = 40;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [BYTE_W-1:0]     text_byte;
    logic                  end_of_text;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [BYTE_W-1:0]     out_byte;
    logic                  last_byte;

    caps_tracker           tracker;

    // Idle controls: sender side is read only by the main process, receiver
    // side is written with nonblocking assignments and read at the edge.
    int                    send_idle_pct;
    int                    stall_pct;
    logic                  hold_token;
    logic                  hold_seen = 1'b0;
    int                    hold_left = 0;

    int                    config_writes;
    logic [BYTE_W-1:0]     text_q [$];

    substring_match_capitalizer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last_byte   (last_byte)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: check every accepted result, then pick ready for the next
    // cycle. A toggle of hold_token starts a long hold counted here.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_out(out_byte, last_byte);
        if (hold_token != hold_seen)
        begin
            hold_seen = hold_token;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Offer one text item and hold it until accepted. Call at a clock edge;
    // valid stays high on return so that back-to-back items need no toggle.
    task automatic send_item(input logic [BYTE_W-1:0] b, input logic eot);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        text_byte   <= b;
        end_of_text <= eot;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        tracker.note_text_item(b, eot);
    endtask

    // Send the queued text, flag the last byte as end of text if asked.
    task automatic send_text_q(input bit terminate);
        int i;
        for (i = 0; i < text_q.size(); i++)
            send_item(text_q[i], terminate && (i == text_q.size() - 1));
        text_q.delete();
    endtask

    task automatic queue_string(input string s);
        int i;
        for (i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endtask

    // Drop valid, wait until every expected result is back, then let the
    // block finish items that release nothing.
    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // Write all three pattern registers back to back; only while idle.
    task automatic write_config(input logic [CFG_DATA_W-1:0] lo,
                                input logic [CFG_DATA_W-1:0] hi,
                                input logic [LEN_W-1:0]      len);
        logic [CFG_DATA_W-1:0] data [3];
        logic [CFG_IDX_W-1:0]  idx [3];
        int                    r;
        idx[0]  = CFG_PATTERN_LOW;
        idx[1]  = CFG_PATTERN_HIGH;
        idx[2]  = CFG_PATTERN_LEN;
        data[0] = lo;
        data[1] = hi;
        // Junk in the upper bits of the length word must be ignored.
        data[2] = {$urandom(), $urandom()};
        data[2][LEN_W-1:0] = len;
        for (r = 0; r < 3; r++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[r];
            cfg_data  <= data[r];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            tracker.set_reg(idx[r], data[r]);
        end
        cfg_valid <= 1'b0;
        config_writes++;
    endtask

    initial
    begin
        int                    p;
        int                    k;
        int                    r;
        int                    n;
        int                    cut;
        int                    mode;
        int                    eff;
        int                    phase_items;
        int                    random_items;
        int                    phase_len [PHASES];
        bit                    terminate;
        bit                    mid_pause_done;
        logic [BYTE_W-1:0]     pat [MAX_PATTERN];
        logic [BYTE_W-1:0]     fill_byte;
        logic [CFG_DATA_W-1:0] lo;
        logic [CFG_DATA_W-1:0] hi;

        tracker        = new();
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_PATTERN_LOW;
        cfg_data       = '0;
        in_valid       = 1'b0;
        text_byte      = '0;
        end_of_text    = 1'b0;
        send_idle_pct  = 0;
        stall_pct      = 0;
        hold_token     = 1'b0;
        config_writes  = 0;
        random_items   = 0;
        mid_pause_done = 1'b0;
        phase_len      = '{2, 16, 0, 31, 1, 3, 17, 4, 5, 2};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- Directed part ----
        // Reset leaves length 0: the byte passes straight through.
        send_item("a", 1'b1);
        settle();

        // Pattern "aba": overlapping hits see bytes already capitalized.
        write_config(64'h0000_0000_0061_6261, 64'hFFFF_FFFF_FFFF_FFFF, 5'd3);
        queue_string("ababa");
        send_text_q(1'b1);
        // End of text before the window fills: released unmodified.
        queue_string("a");
        send_text_q(1'b1);

        // Shorten the length while two bytes are pending.
        queue_string("ab");
        send_text_q(1'b0);
        settle();
        write_config(64'h0000_0000_0061_6261, 64'hFFFF_FFFF_FFFF_FFFF, 5'd1);
        queue_string("ax");
        send_text_q(1'b1);
        settle();

        // Length above the maximum acts as 16; full pattern with 00 and FF.
        write_config(64'h6867_6665_6463_6261, 64'hFF00_6E6D_6C6B_6A69, 5'd31);
        queue_string("abcdefghijklmn");
        text_q.push_back(8'h00);
        text_q.push_back(8'hFF);
        send_text_q(1'b1);

        // ---- Random part ----
        for (p = 0; p < PHASES; p++)
        begin
            settle();
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct <= 0;  end
                1: begin send_idle_pct = 79; stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  stall_pct <= 79; end
                default: begin send_idle_pct = 37; stall_pct <= 37; end
            endcase

            // Pick a pattern: small alphabet for overlaps, mixed case,
            // all 00 or all FF, or fully random bytes.
            mode      = (p == 1 || p == 7) ? 2 : int'($urandom_range(3));
            fill_byte = (p < 5) ? 8'hFF : 8'h00;
            for (k = 0; k < MAX_PATTERN; k++)
            begin
                case (mode)
                    0: pat[k] = 8'("a" + $urandom_range(2));
                    1: pat[k] = $urandom_range(1) ? 8'("A" + $urandom_range(25))
                                                  : 8'("a" + $urandom_range(25));
                    2: pat[k] = fill_byte;
                    default: pat[k] = 8'($urandom_range(255));
                endcase
            end
            for (k = 0; k < 8; k++)
            begin
                lo[8*k +: 8] = pat[k];
                hi[8*k +: 8] = pat[8+k];
            end
            write_config(lo, hi, 5'(phase_len[p]));
            eff = (phase_len[p] > MAX_PATTERN) ? MAX_PATTERN : phase_len[p];

            // Hold the receiver off while the sender keeps offering items.
            if (p == 4)
                hold_token <= ~hold_token;

            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                n = $urandom_range(1, PHASE_ITEMS - phase_items);
                // Mostly whole pattern runs, some cut short, some noise.
                while (text_q.size() < n)
                begin
                    r = $urandom_range(99);
                    if (eff > 0 && r < 45)
                    begin
                        cut = ($urandom_range(4) == 0) ? int'($urandom_range(eff - 1)) : eff;
                        for (k = 0; k < cut; k++) text_q.push_back(pat[k]);
                    end
                    else if (eff > 0 && r < 85)
                        text_q.push_back(pat[$urandom_range(eff - 1)]);
                    else
                        text_q.push_back(8'($urandom_range(255)));
                end
                phase_items  += text_q.size();
                random_items += text_q.size();
                // Leave the last text of a phase open now and then, so the
                // next length is written with bytes pending.
                terminate = (phase_items < PHASE_ITEMS) || (p == PHASES - 1)
                            || ($urandom_range(2) != 0);
                send_text_q(terminate);
                if (p == 6 && !mid_pause_done)
                begin
                    // Pause the sender until every expected byte is back.
                    in_valid <= 1'b0;
                    while (tracker.pending() != 0) @(posedge clk);
                    mid_pause_done = 1'b1;
                end
            end
        end

        settle();
        $display("Ran %0d text items (%0d random) and checked %0d result bytes",
                 tracker.items, random_items, tracker.results);
        $display("over %0d pattern settings, four idle mixes and one long output hold",
                 config_writes);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("Timeout with %0d results still expected", tracker.pending());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
